/* rtl/sev_pkg.sv */
`timescale 1ns / 1ps

package sev_pkg;

	// Fraction bits of the gradient, property and result fields
	localparam int FRAC_BITS = 16;

	localparam int FLD_W = 32;
	localparam int NGRAD = 9;
	localparam int IN_W  = 12 * FLD_W;
	localparam int OUT_W = 3 * FLD_W;

	// 2 S:S is below 2^67; keep an even width for the root
	localparam int ACC_W = 68;
	localparam int MAG_W = ACC_W / 2;
	localparam int STR_LAT = 3 + MAG_W;

	// 2^(5F) / J^2 quotient and its cube root
	localparam int DJ2_W = 2 * FLD_W;
	localparam int QW    = 5 * FRAC_BITS + 1;
	localparam int CW    = (QW + 2) / 3;
	localparam int QPW   = 3 * CW;
	localparam int FLT_LAT = 1 + QW + CW;

	localparam int VSC_LAT = 5;
	localparam int TOT_LAT = FLT_LAT + VSC_LAT;
	localparam int MAG_DLY = FLT_LAT - STR_LAT;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 24;
	localparam int SMAG_W = 16;
	localparam int TURB_W = 24;

	localparam logic [SMAG_W-1:0] SMAG_RST = 16'd11796;
	localparam logic [TURB_W-1:0] PRT_RST  = 24'd163840;
	localparam logic [TURB_W-1:0] SCT_RST  = 24'd65536;

	typedef enum logic [CFG_IW-1:0] {
		REG_SMAG = 2'd0,
		REG_PRT  = 2'd1,
		REG_SCT  = 2'd2
	} cfg_reg_t;

	typedef logic [NGRAD-1:0][FLD_W-1:0] grad_vec_t;

endpackage

/* rtl/smagorinsky_eddy_viscosity.sv */
`timescale 1ns / 1ps
// Throughput: one cell per clock while enabled; the whole pipeline moves on one enable.
// The enable drops only when the output register and the skid entry are both full.
// Reset (arst_n low, asynchronous): all valids clear, registers return to
// Cs = 0.18, 1/Prt = 2.5, 1/Sct = 1.0. Datapath registers are not reset.
module smagorinsky_eddy_viscosity (
	input  logic                          clk,
	input  logic                          arst_n,
	// cell stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// du_dx, du_dy, du_dz, dv_dx, dv_dy, dv_dz, dw_dx, dw_dy, dw_dz,
	// inv_jacobian, density_factor, heat_capacity (32 bits each, from bit 0)
	input  logic [sev_pkg::IN_W-1:0]      s_tdata,
	// result stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// eddy_viscosity, eddy_conductivity, species_diffusivity (32 bits each)
	output logic [sev_pkg::OUT_W-1:0]     m_tdata,
	// saturated
	output logic [0:0]                    m_tuser,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sev_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [sev_pkg::CFG_DW-1:0]    cfg_data
);

	localparam int TOT = sev_pkg::TOT_LAT;
	localparam int FL  = sev_pkg::FLT_LAT;
	localparam int MD  = sev_pkg::MAG_DLY;
	localparam int OW  = sev_pkg::OUT_W;

	// ---- configuration registers ----
	logic [sev_pkg::SMAG_W-1:0] smag_q;
	logic [sev_pkg::TURB_W-1:0] prt_q, sct_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smag_q <= sev_pkg::SMAG_RST;
			prt_q  <= sev_pkg::PRT_RST;
			sct_q  <= sev_pkg::SCT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sev_pkg::REG_SMAG: smag_q <= cfg_data[sev_pkg::SMAG_W-1:0];
				sev_pkg::REG_PRT:  prt_q  <= cfg_data;
				sev_pkg::REG_SCT:  sct_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- pipeline control ----
	logic          en;
	logic          push, pop;
	logic          out_vld_q, skid_vld_q;
	logic [TOT-1:0] vld_q;

	// stall only when both output slots are taken
	assign en       = !(out_vld_q && skid_vld_q);
	assign s_tready = en;
	assign push     = en && vld_q[TOT-1];
	assign pop      = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], s_tvalid};
		end
	end

	// ---- datapath ----
	logic [sev_pkg::MAG_W-1:0] mag;
	logic [sev_pkg::CW-1:0]    d2;
	logic [sev_pkg::MAG_W-1:0] mag_dly_q [0:MD-1];
	logic [31:0]               dens_dly_q [0:FL-1];
	logic [31:0]               hc_dly_q   [0:FL-1];

	sev_strain u_strain (
		.clk  (clk),
		.en   (en),
		.grad (sev_pkg::grad_vec_t'(s_tdata[sev_pkg::NGRAD*32-1:0])),
		.mag  (mag)
	);

	sev_filter u_filter (
		.clk     (clk),
		.en      (en),
		.inv_jac (s_tdata[9*32 +: 32]),
		.d2      (d2)
	);

	// line |S| and the properties up with the filter width
	always_ff @(posedge clk) begin
		if (en) begin
			mag_dly_q[0]  <= mag;
			dens_dly_q[0] <= s_tdata[10*32 +: 32];
			hc_dly_q[0]   <= s_tdata[11*32 +: 32];
			for (int k = 1; k < MD; k++) begin
				mag_dly_q[k] <= mag_dly_q[k-1];
			end
			for (int k = 1; k < FL; k++) begin
				dens_dly_q[k] <= dens_dly_q[k-1];
				hc_dly_q[k]   <= hc_dly_q[k-1];
			end
		end
	end

	logic [31:0] visc, cond, diff;
	logic        sat;

	sev_visc u_visc (
		.clk  (clk),
		.en   (en),
		.d2   (d2),
		.mag  (mag_dly_q[MD-1]),
		.dens (dens_dly_q[FL-1]),
		.hcap (hc_dly_q[FL-1]),
		.smag (smag_q),
		.prt  (prt_q),
		.sct  (sct_q),
		.visc (visc),
		.cond (cond),
		.diff (diff),
		.sat  (sat)
	);

	// ---- output register plus one skid entry ----
	logic [OW-1:0] out_data_q, skid_data_q;
	logic          out_sat_q, skid_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= push;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			out_data_q <= skid_data_q;
			out_sat_q  <= skid_sat_q;
			if (push) begin
				skid_data_q <= {diff, cond, visc};
				skid_sat_q  <= sat;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_data_q <= {diff, cond, visc};
				skid_sat_q  <= sat;
			end else begin
				out_data_q <= {diff, cond, visc};
				out_sat_q  <= sat;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

	// ---- checks ----
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held with empty output register");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_vld_q && !m_tready) |=> skid_vld_q)
		else $error("result pushed during output stall was not parked");

	a_stall_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_q[TOT-1]) |=> vld_q[TOT-1])
		else $error("last pipeline stage lost an item while stalled");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_vld_q) |=> out_vld_q)
		else $error("skid entry not moved to output");

endmodule

/* rtl/sev_strain.sv */
`timescale 1ns / 1ps

// |S| = floor(sqrt(2 S:S)): abs, squares, sum, then one root bit per stage
module sev_strain (
	input  logic                        clk,
	input  logic                        en,
	input  sev_pkg::grad_vec_t          grad,
	output logic [sev_pkg::MAG_W-1:0]   mag
);

	localparam int MW = sev_pkg::MAG_W;
	localparam int AW = sev_pkg::ACC_W;
	localparam int RW = MW + 2;

	logic [2:0][31:0] dabs_c;
	logic [2:0][32:0] oabs_c, osum_c;
	logic [2:0][31:0] dabs_s1;
	logic [2:0][32:0] oabs_s1;
	logic [2:0][63:0] dsq_s2;
	logic [2:0][65:0] osq_s2;
	logic [AW-1:0]    acc_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dabs_c[k] = grad[4*k][31] ? (~grad[4*k] + 32'd1) : grad[4*k];
		end
		osum_c[0] = {grad[1][31], grad[1]} + {grad[3][31], grad[3]};
		osum_c[1] = {grad[2][31], grad[2]} + {grad[6][31], grad[6]};
		osum_c[2] = {grad[5][31], grad[5]} + {grad[7][31], grad[7]};
		for (int k = 0; k < 3; k++) begin
			oabs_c[k] = osum_c[k][32] ? (~osum_c[k] + 33'd1) : osum_c[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dabs_s1 <= dabs_c;
			oabs_s1 <= oabs_c;
			for (int k = 0; k < 3; k++) begin
				dsq_s2[k] <= 64'(dabs_s1[k]) * 64'(dabs_s1[k]);
				osq_s2[k] <= 66'(oabs_s1[k]) * 66'(oabs_s1[k]);
			end
			acc_s3 <= {3'd0, dsq_s2[0], 1'b0} + {3'd0, dsq_s2[1], 1'b0}
				+ {3'd0, dsq_s2[2], 1'b0} + {2'd0, osq_s2[0]}
				+ {2'd0, osq_s2[1]} + {2'd0, osq_s2[2]};
		end
	end

	// root recurrence, two radicand bits per stage
	logic [RW-1:0] rem_s  [1:MW];
	logic [MW-1:0] root_s [1:MW];
	logic [AW-1:0] val_s  [1:MW];
	logic [RW-1:0] rem_c  [0:MW-1];
	logic [MW-1:0] root_c [0:MW-1];
	logic [AW-1:0] val_c  [0:MW-1];
	logic [RW-1:0] rem_n  [0:MW-1];
	logic [MW-1:0] root_n [0:MW-1];
	logic [AW-1:0] val_n  [0:MW-1];

	always_comb begin
		logic [RW-1:0] sh, trial;
		rem_c[0]  = '0;
		root_c[0] = '0;
		val_c[0]  = acc_s3;
		for (int k = 1; k < MW; k++) begin
			rem_c[k]  = rem_s[k];
			root_c[k] = root_s[k];
			val_c[k]  = val_s[k];
		end
		for (int k = 0; k < MW; k++) begin
			sh    = {rem_c[k][RW-3:0], val_c[k][AW-1:AW-2]};
			trial = {root_c[k], 2'b01};
			val_n[k] = {val_c[k][AW-3:0], 2'b00};
			if (sh >= trial) begin
				rem_n[k]  = sh - trial;
				root_n[k] = {root_c[k][MW-2:0], 1'b1};
			end else begin
				rem_n[k]  = sh;
				root_n[k] = {root_c[k][MW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < MW; k++) begin
				rem_s[k+1]  <= rem_n[k];
				root_s[k+1] <= root_n[k];
				val_s[k+1]  <= val_n[k];
			end
		end
	end

	assign mag = root_s[MW];

endmodule

/* rtl/sev_filter.sv */
`timescale 1ns / 1ps

// delta^2 = cbrt(2^(5F) / J^2): square, restoring divide, cube root
module sev_filter (
	input  logic                       clk,
	input  logic                       en,
	input  logic [31:0]                inv_jac,
	output logic [sev_pkg::CW-1:0]     d2
);

	localparam int DW  = sev_pkg::DJ2_W;
	localparam int QW  = sev_pkg::QW;
	localparam int CW  = sev_pkg::CW;
	localparam int QPW = sev_pkg::QPW;
	localparam int R2W = 2 * CW;
	localparam int CRW = 2 * CW + 5;

	logic [31:0]   dj_c;
	logic [DW-1:0] dj2_s1;

	assign dj_c = (inv_jac == 32'd0) ? 32'd1 : inv_jac;

	always_ff @(posedge clk) begin
		if (en) begin
			dj2_s1 <= DW'(dj_c) * DW'(dj_c);
		end
	end

	// divide: one quotient bit per stage, dividend is a single one at the top
	logic [DW-1:0] drem_s [1:QW];
	logic [QW-1:0] quo_s  [1:QW];
	logic [DW-1:0] den_s  [1:QW];
	logic [DW-1:0] drem_c [0:QW-1];
	logic [QW-1:0] quo_c  [0:QW-1];
	logic [DW-1:0] den_c  [0:QW-1];
	logic [DW-1:0] drem_n [0:QW-1];
	logic [QW-1:0] quo_n  [0:QW-1];

	always_comb begin
		logic [DW:0] sh;
		drem_c[0] = '0;
		quo_c[0]  = '0;
		den_c[0]  = dj2_s1;
		for (int k = 1; k < QW; k++) begin
			drem_c[k] = drem_s[k];
			quo_c[k]  = quo_s[k];
			den_c[k]  = den_s[k];
		end
		for (int k = 0; k < QW; k++) begin
			sh = {drem_c[k], 1'(k == 0)};
			if (sh >= {1'b0, den_c[k]}) begin
				drem_n[k] = DW'(sh - {1'b0, den_c[k]});
				quo_n[k]  = {quo_c[k][QW-2:0], 1'b1};
			end else begin
				drem_n[k] = sh[DW-1:0];
				quo_n[k]  = {quo_c[k][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				drem_s[k+1] <= drem_n[k];
				quo_s[k+1]  <= quo_n[k];
				den_s[k+1]  <= den_c[k];
			end
		end
	end

	// cube root: three radicand bits per stage, r^2 carried along
	logic [CRW-1:0] crem_s [1:CW];
	logic [CW-1:0]  rt_s   [1:CW];
	logic [R2W-1:0] rsq_s  [1:CW];
	logic [QPW-1:0] cv_s   [1:CW];
	logic [CRW-1:0] crem_c [0:CW-1];
	logic [CW-1:0]  rt_c   [0:CW-1];
	logic [R2W-1:0] rsq_c  [0:CW-1];
	logic [QPW-1:0] cv_c   [0:CW-1];
	logic [CRW-1:0] crem_n [0:CW-1];
	logic [CW-1:0]  rt_n   [0:CW-1];
	logic [R2W-1:0] rsq_n  [0:CW-1];
	logic [QPW-1:0] cv_n   [0:CW-1];

	always_comb begin
		logic [CRW-1:0] sh, trial, r2x, rx;
		crem_c[0] = '0;
		rt_c[0]   = '0;
		rsq_c[0]  = '0;
		cv_c[0]   = QPW'(quo_s[QW]);
		for (int k = 1; k < CW; k++) begin
			crem_c[k] = crem_s[k];
			rt_c[k]   = rt_s[k];
			rsq_c[k]  = rsq_s[k];
			cv_c[k]   = cv_s[k];
		end
		for (int k = 0; k < CW; k++) begin
			sh    = {crem_c[k][CRW-4:0], cv_c[k][QPW-1:QPW-3]};
			r2x   = CRW'(rsq_c[k]);
			rx    = CRW'(rt_c[k]);
			trial = (r2x << 3) + (r2x << 2) + (rx << 2) + (rx << 1) + CRW'(1);
			cv_n[k] = {cv_c[k][QPW-4:0], 3'b000};
			if (sh >= trial) begin
				crem_n[k] = sh - trial;
				rt_n[k]   = {rt_c[k][CW-2:0], 1'b1};
				rsq_n[k]  = (rsq_c[k] << 2) + (R2W'(rt_c[k]) << 2) + R2W'(1);
			end else begin
				crem_n[k] = sh;
				rt_n[k]   = {rt_c[k][CW-2:0], 1'b0};
				rsq_n[k]  = rsq_c[k] << 2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < CW; k++) begin
				crem_s[k+1] <= crem_n[k];
				rt_s[k+1]   <= rt_n[k];
				rsq_s[k+1]  <= rsq_n[k];
				cv_s[k+1]   <= cv_n[k];
			end
		end
	end

	assign d2 = rt_s[CW];

endmodule

/* rtl/sev_visc.sv */
`timescale 1ns / 1ps

// Product chain: t, nu, mu / D, mu*cp, kappa; saturating at 32 bits
module sev_visc (
	input  logic                          clk,
	input  logic                          en,
	input  logic [sev_pkg::CW-1:0]        d2,
	input  logic [sev_pkg::MAG_W-1:0]     mag,
	input  logic [31:0]                   dens,
	input  logic [31:0]                   hcap,
	input  logic [sev_pkg::SMAG_W-1:0]    smag,
	input  logic [sev_pkg::TURB_W-1:0]    prt,
	input  logic [sev_pkg::TURB_W-1:0]    sct,
	output logic [31:0]                   visc,
	output logic [31:0]                   cond,
	output logic [31:0]                   diff,
	output logic                          sat
);

	localparam int F   = sev_pkg::FRAC_BITS;
	localparam int CW  = sev_pkg::CW;
	localparam int MW  = sev_pkg::MAG_W;
	localparam int TW  = sev_pkg::TURB_W;
	localparam int TPW = 32 + CW;
	localparam int NPW = CW + MW;
	localparam int PW  = 64 - F;
	localparam int KPW = PW + TW;
	localparam int DPW = 32 + TW;

	logic [31:0]     cs2_q;
	logic [TPW-1:0]  tp_c;
	logic [NPW-1:0]  np_c;
	logic [63:0]     mp_c, pp_c;
	logic [DPW-1:0]  dp_c;
	logic [KPW-1:0]  kp_c;

	logic [CW-1:0]   t_s1;
	logic [MW-1:0]   mag_s1;
	logic [31:0]     dens_s1, hc_s1;
	logic [31:0]     nu_s2, dens_s2, hc_s2;
	logic            clip_s2;
	logic [31:0]     mu_s3, dif_s3, hc_s3;
	logic            clip_s3;
	logic [PW-1:0]   p_s4;
	logic [31:0]     mu_s4, dif_s4;
	logic            clip_s4;
	logic [31:0]     mu_s5, kap_s5, dif_s5;
	logic            clip_s5;

	// Cs^2 follows the register; write only while idle (not enforced)
	always_ff @(posedge clk) begin
		cs2_q <= 32'(smag) * 32'(smag);
	end

	assign tp_c = TPW'(cs2_q) * TPW'(d2);
	assign np_c = NPW'(t_s1) * NPW'(mag_s1);
	assign mp_c = 64'(nu_s2) * 64'(dens_s2);
	assign dp_c = DPW'(nu_s2) * DPW'(sct);
	assign pp_c = 64'(mu_s3) * 64'(hc_s3);
	assign kp_c = KPW'(p_s4) * KPW'(prt);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= tp_c[TPW-1:32];
			mag_s1  <= mag;
			dens_s1 <= dens;
			hc_s1   <= hcap;

			nu_s2   <= (|np_c[NPW-1:F+32]) ? 32'hFFFF_FFFF : np_c[F+31:F];
			clip_s2 <= |np_c[NPW-1:F+32];
			dens_s2 <= dens_s1;
			hc_s2   <= hc_s1;

			mu_s3   <= (|mp_c[63:F+32]) ? 32'hFFFF_FFFF : mp_c[F+31:F];
			dif_s3  <= (|dp_c[DPW-1:48]) ? 32'hFFFF_FFFF : dp_c[47:16];
			clip_s3 <= clip_s2 | (|mp_c[63:F+32]) | (|dp_c[DPW-1:48]);
			hc_s3   <= hc_s2;

			p_s4    <= pp_c[63:F];
			mu_s4   <= mu_s3;
			dif_s4  <= dif_s3;
			clip_s4 <= clip_s3;

			kap_s5  <= (|kp_c[KPW-1:48]) ? 32'hFFFF_FFFF : kp_c[47:16];
			clip_s5 <= clip_s4 | (|kp_c[KPW-1:48]);
			mu_s5   <= mu_s4;
			dif_s5  <= dif_s4;
		end
	end

	assign visc = mu_s5;
	assign cond = kap_s5;
	assign diff = dif_s5;
	assign sat  = clip_s5;

endmodule

/* test/smagorinsky_eddy_viscosity_tb.sv */
`timescale 1ns / 1ps

module smagorinsky_eddy_viscosity_tb;
	import sev_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int ITEMS_PER_SET = 270;
	// index past the register list, must be ignored by the block
	localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

	typedef struct {
		grad_vec_t   grad;
		logic [31:0] inv_jac;
		logic [31:0] density;
		logic [31:0] heat_cap;
	} cell_t;

	typedef struct {
		logic [31:0] visc;
		logic [31:0] cond;
		logic [31:0] diff;
		logic        sat;
	} terms_t;

	// Keeps its own copy of the registers and a queue of predicted terms.
	class eddy_scoreboard;
		logic [SMAG_W-1:0] cs;
		logic [TURB_W-1:0] inv_prt;
		logic [TURB_W-1:0] inv_sct;
		terms_t            pending_terms[$];
		int                errors;

		function new();
			cs = SMAG_RST;
			inv_prt = PRT_RST;
			inv_sct = SCT_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_SMAG: cs = val[SMAG_W-1:0];
				REG_PRT:  inv_prt = val;
				REG_SCT:  inv_sct = val;
				default:  ;
			endcase
		endfunction

		function logic [127:0] square(logic signed [33:0] v);
			logic [127:0] w;
			w = (v < 0) ? -v : v;
			return w * w;
		endfunction

		function logic [31:0] clip32(logic [127:0] v, inout bit clipped);
			if (v > 128'hFFFF_FFFF) begin
				clipped = 1;
				return 32'hFFFF_FFFF;
			end
			return v[31:0];
		endfunction

		function terms_t eddy_terms(cell_t c);
			logic signed [33:0] g[9];
			logic [127:0] acc, q, w, dj, t, nu, mu, p;
			logic [63:0]  mag, cube_root, trial;
			terms_t       r;
			bit           clipped;
			clipped = 0;
			for (int i = 0; i < 9; i++)
				g[i] = $signed(c.grad[i]);
			// 2 S:S, exact with 2F fraction bits
			acc = 2 * (square(g[0]) + square(g[4]) + square(g[8]))
				+ square(g[1] + g[3]) + square(g[2] + g[6]) + square(g[5] + g[7]);
			mag = 0;
			for (int b = 63; b >= 0; b--) begin
				trial = mag | (64'd1 << b);
				w = trial;
				if (w * w <= acc)
					mag = trial;
			end
			// delta^2 = cbrt(2^(5F) / J^2); zero inverse Jacobian acts as one
			dj = (c.inv_jac == 0) ? 128'd1 : c.inv_jac;
			q = (128'd1 << (5 * FRAC_BITS)) / (dj * dj);
			cube_root = 0;
			for (int b = 41; b >= 0; b--) begin
				trial = cube_root | (64'd1 << b);
				w = trial;
				if (w * w * w <= q)
					cube_root = trial;
			end
			w = cs;
			t = (w * w * cube_root) >> 32;
			nu = clip32((t * mag) >> FRAC_BITS, clipped);
			mu = clip32((nu * c.density) >> FRAC_BITS, clipped);
			p = (mu * c.heat_cap) >> FRAC_BITS;
			r.visc = mu[31:0];
			r.cond = clip32((p * inv_prt) >> 16, clipped);
			r.diff = clip32((nu * inv_sct) >> 16, clipped);
			r.sat = clipped;
			return r;
		endfunction

		function void note_cell(cell_t c);
			pending_terms.push_back(eddy_terms(c));
		endfunction

		function void check_terms(terms_t got);
			terms_t want;
			if (pending_terms.size() == 0) begin
				$error("result with nothing expected: visc %h cond %h diff %h sat %b",
					got.visc, got.cond, got.diff, got.sat);
				errors++;
				return;
			end
			want = pending_terms.pop_front();
			if (got.visc !== want.visc) begin
				$error("eddy_viscosity: expected %h, got %h", want.visc, got.visc);
				errors++;
			end
			if (got.cond !== want.cond) begin
				$error("eddy_conductivity: expected %h, got %h", want.cond, got.cond);
				errors++;
			end
			if (got.diff !== want.diff) begin
				$error("species_diffusivity: expected %h, got %h", want.diff, got.diff);
				errors++;
			end
			if (got.sat !== want.sat) begin
				$error("saturated: expected %b, got %b", want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [0:0]        m_tuser;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	eddy_scoreboard sb = new();
	int  cycles = 0;
	int  cells_in = 0;
	// when set, the matching side adds no random idle gaps
	bit  send_busy = 0;
	bit  recv_busy = 0;

	smagorinsky_eddy_viscosity i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// mostly short gaps, some long ones
	function automatic int idle_len(bit busy);
		int r;
		if (busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one cell transfer; returns at the falling edge after acceptance
	task automatic send_cell(cell_t c);
		int gap;
		gap = idle_len(send_busy);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {c.heat_cap, c.density, c.inv_jac, c.grad};
		do @(posedge clk); while (!s_tready);
		sb.note_cell(c);
		cells_in++;
		@(negedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// pipeline empty and nothing left in flight
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending_terms.size() != 0)
			@(negedge clk);
		repeat (TOT_LAT + 10) @(negedge clk);
	endtask

	function automatic logic [31:0] scaled_value();
		return $urandom() >> $urandom_range(0, 31);
	endfunction

	function automatic logic [31:0] scaled_grad();
		logic signed [31:0] v;
		v = $urandom();
		return v >>> $urandom_range(0, 30);
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		if ($urandom_range(0, 3) == 0) begin
			// raw noise over the whole field range
			for (int i = 0; i < NGRAD; i++)
				c.grad[i] = $urandom();
			c.inv_jac = $urandom();
			c.density = $urandom();
			c.heat_cap = $urandom();
		end else begin
			// magnitudes spread over many scales
			for (int i = 0; i < NGRAD; i++)
				c.grad[i] = scaled_grad();
			c.inv_jac = scaled_value();
			c.density = scaled_value();
			c.heat_cap = scaled_value();
		end
		return c;
	endfunction

	function automatic cell_t uniform_cell(logic [31:0] g, logic [31:0] j,
			logic [31:0] d, logic [31:0] h);
		cell_t c;
		for (int i = 0; i < NGRAD; i++)
			c.grad[i] = g;
		c.inv_jac = j;
		c.density = d;
		c.heat_cap = h;
		return c;
	endfunction

	task automatic directed_cells();
		cell_t c;
		send_cell(uniform_cell(32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000));
		send_cell(uniform_cell(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000));
		send_cell(uniform_cell(32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_cell(uniform_cell(32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_cell(uniform_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
		// zero inverse Jacobian gives the widest filter
		send_cell(uniform_cell(32'h1_0000, 32'h0, 32'h1_0000, 32'h1_0000));
		send_cell(uniform_cell(32'h0010_0000, 32'h0, 32'h0100_0000, 32'h0001_0000));
		send_cell(uniform_cell(32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1));
		send_cell(uniform_cell(32'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_cell(uniform_cell(32'hFFF0_0000, 32'h0000_8000, 32'h1_0000, 32'h0));
		// one gradient at a time, opposite shear pairs cancel
		for (int i = 0; i < NGRAD; i++) begin
			c = uniform_cell(32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
			c.grad[i] = 32'h0003_0000;
			send_cell(c);
		end
		c = uniform_cell(32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
		c.grad[1] = 32'h0002_0000;
		c.grad[3] = 32'hFFFE_0000;
		send_cell(c);
		c.grad[1] = 32'h8000_0000;
		c.grad[3] = 32'h8000_0000;
		send_cell(c);
	endtask

	// register settings per phase: reset, all low, all high, random
	task automatic configure(int phase);
		case (phase)
			1: begin
				write_cfg(REG_SMAG, 24'h0);
				write_cfg(REG_PRT, 24'h0);
				write_cfg(REG_SCT, 24'h0);
			end
			2: begin
				write_cfg(REG_SMAG, 24'hFFFFFF);
				write_cfg(REG_PRT, 24'hFFFFFF);
				write_cfg(REG_SCT, 24'hFFFFFF);
				write_cfg(REG_NONE, 24'h000123);
			end
			default: begin
				write_cfg(REG_SCT, CFG_DW'($urandom()));
				write_cfg(REG_SMAG, CFG_DW'($urandom()));
				write_cfg(REG_PRT, CFG_DW'($urandom()));
				write_cfg(REG_NONE, CFG_DW'($urandom()));
			end
		endcase
		cfg_valid <= 0;
	endtask

	// result side: random stalls, plus one long hold-off to back the pipe up
	initial begin
		int  hold;
		bit  held;
		terms_t got;
		held = 0;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && cells_in >= 400) begin
				held = 1;
				m_tready <= 0;
				hold = 600;
				while (hold > 0) begin
					@(negedge clk);
					hold--;
				end
			end
			hold = idle_len(recv_busy);
			if (hold > 0) begin
				m_tready <= 0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			if (m_tvalid) begin
				got.visc = m_tdata[31:0];
				got.cond = m_tdata[63:32];
				got.diff = m_tdata[95:64];
				got.sat = m_tuser[0];
				sb.check_terms(got);
			end
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_SMAG;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		directed_cells();
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				drain();
				configure(phase);
			end
			for (int n = 0; n < ITEMS_PER_SET; n++) begin
				// stretches with and without idling, redrawn at random every 64 cells
				if (n % 64 == 0) begin
					send_busy = ($urandom_range(0, 3) == 0);
					recv_busy = ($urandom_range(0, 3) == 0);
				end
				send_cell(random_cell());
			end
		end
		drain();

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
rtl/sev_pkg.sv
rtl/sev_strain.sv
rtl/sev_filter.sv
rtl/sev_visc.sv
rtl/smagorinsky_eddy_viscosity.sv
test/smagorinsky_eddy_viscosity_tb.sv
